>>> hw/rtl/imuarms_pkg.sv
// Package for imu_align_running_rms: sequencer states and fixed formats.
// No dependencies.
`timescale 1ns / 1ps

package imuarms_pkg;

  localparam int VAL_W    = 32;
  localparam int MS_W     = 64;
  localparam int RECIP_W  = 32;
  localparam int ROW_W    = 54;
  localparam int SCALE_SH = 8;
  localparam int COEF_SH  = 16;

  localparam logic [2:0] CFG_ROW0  = 3'd0;
  localparam logic [2:0] CFG_ROW1  = 3'd1;
  localparam logic [2:0] CFG_ROW2  = 3'd2;
  localparam logic [2:0] CFG_ACCEL = 3'd3;
  localparam logic [2:0] CFG_GYRO  = 3'd4;
  localparam logic [2:0] CFG_MAG   = 3'd5;

  localparam logic [1:0] GRP_MAG = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROT,
    ST_ROTSUM,
    ST_SQ,
    ST_RDMS,
    ST_DIFF,
    ST_DIV,
    ST_WRMS,
    ST_SQRT,
    ST_NEXT,
    ST_OUT
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [71:0] v);
    if (v > 72'sh0_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -72'sh0_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/imu_align_running_rms.sv
// imu_align_running_rms top level: sequencer, multipliers, divider and root.
// Depends on imuarms_pkg.
`timescale 1ns / 1ps

// One input beat of nine raw samples yields three output beats (accel, gyro, mag).
// Work is done one axis at a time by separate scale, rotate and square multipliers, a bit-serial 64-bit
// divider (one quotient bit per cycle) and a bit-serial square root (one result
// bit per cycle); the running mean squares sit in a 9-entry memory with a
// registered read. Each axis is rotated, set up (square, memory read, difference),
// divided, written back, rooted and stored; each group adds scaling before its axes
// and an output beat after them. Holding m_tready low stalls the sequencer on the
// output beat. A new beat is taken once all three results of the previous one have
// been delivered.
module imu_align_running_rms
  import imuarms_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [ROW_W-1:0]            cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // accel x,y,z, gyro x,y,z, mag x,y,z from the lowest bit up
  input  logic [((9*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // sensor_group, x,y,z value, x,y,z rms from the lowest bit up
  output logic [199:0]                m_tdata,
  output logic                        m_tlast
);

  localparam int CW = COEF_WIDTH;
  localparam int RW = (3*CW > ROW_W) ? 3*CW : ROW_W;

  logic [RW-1:0]      row0, row1, row2;
  logic [RECIP_W-1:0] recip_a, recip_g, recip_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0    <= RW'(64'd65536 << (2*CW));
      row1    <= RW'(64'd65536 << CW);
      row2    <= RW'(64'd65536);
      recip_a <= 32'd8389;
      recip_g <= 32'd8389;
      recip_m <= 32'd2517212;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW0:  row0 <= RW'(cfg_data);
        CFG_ROW1:  row1 <= RW'(cfg_data);
        CFG_ROW2:  row2 <= RW'(cfg_data);
        CFG_ACCEL: recip_a <= cfg_data[RECIP_W-1:0];
        CFG_GYRO:  recip_g <= cfg_data[RECIP_W-1:0];
        CFG_MAG:   recip_m <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // mean-square memory, cleared entries tracked by valid bits
  logic [MS_W-1:0] ms_mem [9];
  logic [8:0]      ms_vld;
  logic [3:0]      ms_addr;
  logic            ms_we;
  logic [MS_W-1:0] ms_wdata, ms_rd;
  logic            ms_rd_vld;

  always_ff @(posedge clk) begin
    if (ms_we) ms_mem[ms_addr] <= ms_wdata;
    ms_rd     <= ms_mem[ms_addr];
    ms_rd_vld <= ms_vld[ms_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) ms_vld <= '0;
    else if (ms_we) ms_vld[ms_addr] <= 1'b1;
  end

  state_t state, state_next;
  logic [9*SAMPLE_WIDTH-1:0] samp;
  logic [1:0]  grp;
  logic [1:0]  idx;     // axis within group, used both for scaling and rotation
  logic [COUNT_WIDTH-1:0] count;
  logic signed [VAL_W-1:0] scaled [3];
  logic signed [VAL_W-1:0] vals [3];
  logic [VAL_W-1:0]        rms [3];
  logic signed [71:0] acc;
  logic signed [VAL_W-1:0] v;
  logic [MS_W-1:0] sq, ms_cur, dnum;
  logic            dneg;
  logic [MS_W-1:0] quo, rem;
  logic [COUNT_WIDTH:0] divisor;
  logic [6:0]  cnt;
  logic [MS_W-1:0] sq_v, sq_r;
  logic [MS_W+1:0] sq_rem;
  logic [5:0] j;

  logic [RECIP_W-1:0] recip;
  logic [RW-1:0]      row;
  logic signed [SAMPLE_WIDTH-1:0] raw;
  logic signed [CW-1:0] cf;
  logic signed [SAMPLE_WIDTH+RECIP_W:0] prod_s;
  logic signed [CW+VAL_W-1:0] prod_r;
  logic [MS_W:0] rsub;
  logic [MS_W+1:0] strial;

  always_comb begin
    unique case (grp)
      2'd0: recip = recip_a;
      2'd1: recip = recip_g;
      default: recip = recip_m;
    endcase
    unique case (idx)
      2'd0: row = row0;
      2'd1: row = row1;
      default: row = row2;
    endcase
    raw    = samp[(32'(grp)*3 + 32'(idx))*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    prod_s = (SAMPLE_WIDTH+RECIP_W+1)'(raw) * $signed({1'b0, recip});
    cf     = row[(2 - 32'(j[1:0]))*CW +: CW];
    prod_r = (CW+VAL_W)'(cf) * (CW+VAL_W)'(scaled[j[1:0]]);
    rsub   = {rem[MS_W-1:0], quo[MS_W-1]} - {{(MS_W-COUNT_WIDTH){1'b0}}, divisor};
    strial = {sq_rem[MS_W-1:0], sq_v[MS_W-1 -: 2]} - {sq_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && m_tready && grp == GRP_MAG && count != '1)
        count <= count + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ms_we      = 1'b0;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SCALE;
      ST_SCALE:  if (idx == 2'd2) state_next = ST_ROT;
      ST_ROT:    if (j == 6'd2) state_next = ST_ROTSUM;
      ST_ROTSUM: state_next = ST_SQ;
      ST_SQ:     state_next = ST_RDMS;
      ST_RDMS:   state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_DIV;
      ST_DIV:    if (cnt == 7'd63) state_next = ST_WRMS;
      ST_WRMS: begin
        ms_we      = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT:   if (cnt == 7'd31) state_next = ST_NEXT;
      ST_NEXT:   state_next = (idx == 2'd2) ? ST_OUT : ST_ROT;
      ST_OUT: begin
        if (m_tready) state_next = (grp == GRP_MAG) ? ST_IDLE : ST_SCALE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  assign ms_addr  = 4'(32'(grp)*3 + 32'(idx));
  assign ms_wdata = dneg ? ms_cur - quo : ms_cur + quo;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = (grp == GRP_MAG);
  assign m_tdata  = {6'd0, rms[2], rms[1], rms[0], vals[2], vals[1], vals[0], grp};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        samp <= s_tdata[9*SAMPLE_WIDTH-1:0];
        grp  <= 2'd0;
        idx  <= 2'd0;
        j    <= '0;
        acc  <= '0;
      end
      ST_SCALE: begin
        scaled[idx] <= sat32(72'(prod_s >>> SCALE_SH));
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        j   <= '0;
        acc <= '0;
      end
      ST_ROT: begin
        acc <= acc + 72'(prod_r);
        j   <= j + 6'd1;
      end
      ST_ROTSUM: begin
        v <= sat32(acc >>> COEF_SH);
      end
      ST_SQ: begin
        sq      <= 64'(v[VAL_W-1] ? -33'(v) : 33'(v)) * 64'(v[VAL_W-1] ? -33'(v) : 33'(v));
        divisor <= 33'(count) + 33'd1;
      end
      ST_RDMS: ;
      ST_DIFF: begin
        ms_cur <= ms_rd_vld ? ms_rd : '0;
        dneg   <= sq < (ms_rd_vld ? ms_rd : '0);
        quo    <= (sq < (ms_rd_vld ? ms_rd : '0)) ? (ms_rd_vld ? ms_rd : '0) - sq
                                                  : sq - (ms_rd_vld ? ms_rd : '0);
        rem    <= '0;
        cnt    <= '0;
      end
      ST_DIV: begin
        if (!rsub[MS_W]) begin
          rem <= rsub[MS_W-1:0];
          quo <= {quo[MS_W-2:0], 1'b1};
        end else begin
          rem <= {rem[MS_W-2:0], quo[MS_W-1]};
          quo <= {quo[MS_W-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
      end
      ST_WRMS: begin
        sq_v   <= ms_wdata;
        sq_r   <= '0;
        sq_rem <= '0;
        cnt    <= '0;
      end
      ST_SQRT: begin
        sq_v <= {sq_v[MS_W-3:0], 2'b00};
        if (!strial[MS_W+1]) begin
          sq_rem <= strial;
          sq_r   <= {sq_r[MS_W-2:0], 1'b1};
        end else begin
          sq_rem <= {sq_rem[MS_W-1:0], sq_v[MS_W-1 -: 2]};
          sq_r   <= {sq_r[MS_W-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
      end
      ST_NEXT: begin
        vals[idx] <= v;
        rms[idx]  <= sq_r[VAL_W-1:0];
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        j   <= '0;
        acc <= '0;
      end
      ST_OUT: begin
        if (m_tready) grp <= grp + 2'd1;
      end
      default: ;
    endcase
  end

endmodule
